@@ sv/ms_pkg.sv @@
// ----------------------------------------------------------------------------
// ms_pkg: shared types and constants of the merge sorter
// Payload structs, controller states, and the command/status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package ms_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int STORE_DEPTH = 64;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } ms_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     end_of_run;
      logic                     overflow;
   } ms_rsp_type;

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_PASS_CHECK,
      ST_RUN_SETUP,
      ST_PRIME_A,
      ST_PRIME_B,
      ST_MERGE,
      ST_RUN_CHECK,
      ST_EMIT_RD,
      ST_EMIT_LD
   } ms_state_type;

   typedef struct packed {
      logic store;      // write the accepted value into the element store
      logic sort_init;  // start the first pass
      logic run_setup;  // compute bounds of the next run pair
      logic prime_a;    // fetch head of left run
      logic prime_b;    // fetch head of right run, latch left head
      logic merge;      // move one element into the destination bank
      logic next_run;   // step to the next run pair
      logic next_pass;  // double the run width and swap banks
      logic emit_rd;    // read next sorted element
      logic emit_ld;    // load the output register
   } ms_cmd_type;

   typedef struct packed {
      logic more_passes; // run width still below element count
      logic more_runs;   // run start still below element count
      logic run_done;    // current merge writes the last slot of its run
      logic slot_free;   // output register can take a new result
      logic emit_last;   // element being emitted is the final one
   } ms_stat_type;

endpackage

@@ sv/ms_ram.sv @@
// ----------------------------------------------------------------------------
// ms_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ms_ctrl.sv @@
// ----------------------------------------------------------------------------
// ms_ctrl: merge sorter sequencer
// Steps through collect, bottom-up merge passes and emit.
// ----------------------------------------------------------------------------
module ms_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_stall,
   input  ms_pkg::ms_stat_type stat,
   output ms_pkg::ms_cmd_type  cmd
);
   import ms_pkg::*;

   ms_state_type state_ff;
   ms_state_type state_in;
   logic         accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_COLLECT);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_COLLECT: begin
            cmd.store     = accept;
            cmd.sort_init = accept & req_last;
            if (accept && req_last) begin
               state_in = ST_PASS_CHECK;
            end
         end
         ST_PASS_CHECK: begin
            state_in = stat.more_passes ? ST_RUN_SETUP : ST_EMIT_RD;
         end
         ST_RUN_SETUP: begin
            cmd.run_setup = 1'b1;
            state_in      = ST_PRIME_A;
         end
         ST_PRIME_A: begin
            cmd.prime_a = 1'b1;
            state_in    = ST_PRIME_B;
         end
         ST_PRIME_B: begin
            cmd.prime_b = 1'b1;
            state_in    = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            if (stat.run_done) begin
               cmd.next_run = 1'b1;
               state_in     = ST_RUN_CHECK;
            end
         end
         ST_RUN_CHECK: begin
            if (stat.more_runs) begin
               state_in = ST_RUN_SETUP;
            end else begin
               cmd.next_pass = 1'b1;
               state_in      = ST_PASS_CHECK;
            end
         end
         ST_EMIT_RD: begin
            if (stat.slot_free) begin
               cmd.emit_rd = 1'b1;
               state_in    = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: begin
            cmd.emit_ld = 1'b1;
            state_in    = stat.emit_last ? ST_COLLECT : ST_EMIT_RD;
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

endmodule

@@ sv/ms_datapath.sv @@
// ----------------------------------------------------------------------------
// ms_datapath: merge sorter storage, run pointers and output register
// Two RAM banks used ping-pong; one element merged per cycle.
// ----------------------------------------------------------------------------
module ms_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ms_pkg::ms_req_type  req_data,
   input  ms_pkg::ms_cmd_type  cmd,
   output ms_pkg::ms_stat_type stat,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ms_pkg::ms_rsp_type  rsp_data
);
   import ms_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             drop_ff, drop_in;
   logic [CNT_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] e_ff, e_in;
   logic             src_ff, src_in;
   logic             a_port_ff, a_port_in;
   logic             b_port_ff, b_port_in;
   logic signed [DATA_W-1:0] a_ff, a_in;
   logic signed [DATA_W-1:0] b_ff, b_in;
   ms_rsp_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [CNT_W:0]   lo_plus_w;
   logic [CNT_W:0]   lo_plus_2w;
   logic [CNT_W-1:0] i_next;
   logic [CNT_W-1:0] j_next;
   logic signed [DATA_W-1:0] rd_sel;
   logic signed [DATA_W-1:0] head_a;
   logic signed [DATA_W-1:0] head_b;
   logic             take_a;
   logic signed [DATA_W-1:0] merge_val;
   logic             room;

   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr0;
   logic [DATA_W-1:0] wr_data0;
   logic              we0;
   logic              we1;
   logic [DATA_W-1:0] rd_data0;
   logic [DATA_W-1:0] rd_data1;

   ms_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_bank0 (
      .clock   (clock),
      .wr_en   (we0),
      .wr_addr (wr_addr0),
      .wr_data (wr_data0),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   ms_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_bank1 (
      .clock   (clock),
      .wr_en   (we1),
      .wr_addr (k_ff[ADDR_W-1:0]),
      .wr_data (merge_val),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   // run heads come straight off the read port in the cycle after a fetch
   assign rd_sel    = src_ff ? $signed(rd_data1) : $signed(rd_data0);
   assign head_a    = a_port_ff ? rd_sel : a_ff;
   assign head_b    = b_port_ff ? rd_sel : b_ff;
   assign take_a    = (i_ff < mid_ff) && ((j_ff >= hi_ff) || (head_a < head_b));
   assign merge_val = take_a ? head_a : head_b;
   assign i_next    = i_ff + CNT_W'(1);
   assign j_next    = j_ff + CNT_W'(1);
   assign room      = cnt_ff < CNT_W'(MAX_ITEMS);

   assign lo_plus_w  = {1'b0, lo_ff} + {1'b0, width_ff};
   assign lo_plus_2w = {1'b0, lo_ff} + {width_ff, 1'b0};

   always_comb begin
      if (cmd.prime_a) begin
         rd_addr = i_ff[ADDR_W-1:0];
      end else if (cmd.prime_b) begin
         rd_addr = j_ff[ADDR_W-1:0];
      end else if (cmd.merge) begin
         rd_addr = take_a ? i_next[ADDR_W-1:0] : j_next[ADDR_W-1:0];
      end else begin
         rd_addr = e_ff[ADDR_W-1:0];
      end
   end

   assign we0      = (cmd.store & room) | (cmd.merge & src_ff);
   assign we1      = cmd.merge & ~src_ff;
   assign wr_addr0 = cmd.store ? cnt_ff[ADDR_W-1:0] : k_ff[ADDR_W-1:0];
   assign wr_data0 = cmd.store ? req_data.value : merge_val;

   always_comb begin
      cnt_in       = cnt_ff;
      drop_in      = drop_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      src_in       = src_ff;
      a_port_in    = a_port_ff;
      b_port_in    = b_port_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (cmd.store) begin
         if (room) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            drop_in = 1'b1;
         end
      end
      if (cmd.sort_init) begin
         width_in = CNT_W'(1);
         src_in   = 1'b0;
         lo_in    = '0;
         e_in     = '0;
      end
      if (cmd.run_setup) begin
         mid_in = (lo_plus_w > {1'b0, cnt_ff}) ? cnt_ff : lo_plus_w[CNT_W-1:0];
         hi_in  = (lo_plus_2w > {1'b0, cnt_ff}) ? cnt_ff : lo_plus_2w[CNT_W-1:0];
         i_in   = lo_ff;
         j_in   = (lo_plus_w > {1'b0, cnt_ff}) ? cnt_ff : lo_plus_w[CNT_W-1:0];
         k_in   = lo_ff;
      end
      if (cmd.prime_b) begin
         a_in      = rd_sel;
         a_port_in = 1'b0;
         b_port_in = 1'b1;
      end
      if (cmd.merge) begin
         a_in      = head_a;
         b_in      = head_b;
         k_in      = k_ff + CNT_W'(1);
         a_port_in = take_a;
         b_port_in = ~take_a;
         if (take_a) begin
            i_in = i_next;
         end else begin
            j_in = j_next;
         end
      end
      if (cmd.next_run) begin
         lo_in = lo_plus_2w[CNT_W-1:0];
      end
      if (cmd.next_pass) begin
         width_in = {width_ff[CNT_W-2:0], 1'b0};
         src_in   = ~src_ff;
         lo_in    = '0;
      end
      if (cmd.emit_ld) begin
         rsp_in.sorted_value = rd_sel;
         rsp_in.end_of_run   = stat.emit_last;
         rsp_in.overflow     = drop_ff;
         rsp_valid_in        = 1'b1;
         e_in                = e_ff + CNT_W'(1);
         if (stat.emit_last) begin
            cnt_in  = '0;
            drop_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff  <= width_in;
      lo_ff     <= lo_in;
      mid_ff    <= mid_in;
      hi_ff     <= hi_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      e_ff      <= e_in;
      src_ff    <= src_in;
      a_port_ff <= a_port_in;
      b_port_ff <= b_port_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      rsp_ff    <= rsp_in;
   end

   assign stat.more_passes = width_ff < cnt_ff;
   assign stat.more_runs   = lo_ff < cnt_ff;
   assign stat.run_done    = (k_ff + CNT_W'(1)) == hi_ff;
   assign stat.slot_free   = ~rsp_valid_ff | ~rsp_stall;
   assign stat.emit_last   = (e_ff + CNT_W'(1)) == cnt_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/merge_sorter_core.sv @@
// ----------------------------------------------------------------------------
// merge_sorter_core: streaming merge sort of signed 32-bit values
// Collects a sequence, sorts it bottom-up, and streams it out ascending.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one value per transfer; req_data.last closes the sequence.
//   Up to MAX_ITEMS values are kept; extra values are dropped and every
//   result of that sequence then carries overflow.
//   rsp_* returns the values in ascending order, end_of_run on the last one.
//   A sequence of n values gives n results (MAX_ITEMS when n is larger).
// Timing:
//   Collect accepts values while req_stall is low. Sorting runs ceil(log2 n)
//   passes over a ping-pong pair of single-read-port RAMs; each pass moves
//   one element per cycle plus a setup, two head fetches and a check per run
//   pair, and there is one pass check per pass plus a final one before emit.
//   Emit reads each result through the registered RAM read, then loads it
//   into the output register once that register is free of a stalled result.
// Reset: returns to collecting with an empty store; RAM contents are not
//   cleared (only values written in the current sequence are ever read).
// Stall: req_stall is high from the closing value until the last result is
//   loaded; a stalled result holds in the output register and the emit
//   sequencer waits for it. The next sequence may start while the final
//   result still waits.
// ----------------------------------------------------------------------------
module merge_sorter_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ms_pkg::ms_req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ms_pkg::ms_rsp_type rsp_data
);
   import ms_pkg::*;

   ms_cmd_type  cmd;
   ms_stat_type stat;

   // sequencer: decides what the datapath does each cycle
   ms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage banks, run pointers, merge compare and output register
   ms_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/ms_checker.sv @@
// ----------------------------------------------------------------------------
// ms_checker: port-level checks of the merge sorter
// Watches both channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module ms_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input ms_pkg::ms_req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input ms_pkg::ms_rsp_type rsp_data
);
   import ms_pkg::*;

   // no result survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // closing value starts sorting, so input closes
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last |=> req_stall)
      else $error("input open after closing value");

   // mid-sequence result transfer means emit is still running
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.end_of_run |=> req_stall)
      else $error("input open while emitting");

   // while collecting, only the final result of the previous run can wait
   a_collect_tail: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid || rsp_data.end_of_run)
      else $error("non-final result pending while collecting");

endmodule

bind merge_sorter_core ms_checker u_ms_checker (.*);
